>>> sv/rgb_to_yuv420_planar_unit_assert.svh
// Assertion helpers used by the converter back end.
`ifndef RGB_TO_YUV420_PLANAR_UNIT_ASSERT_SVH
`define RGB_TO_YUV420_PLANAR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define RYUV_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define RYUV_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ryuv_pkg.sv
`timescale 1ns / 1ps

package ryuv_pkg;

    localparam int OFF_W = 23;
    localparam int PIX_W = 8;
    localparam int CFG_W = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = 1;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    localparam logic [15:0] COEF_Y_R = 16'd66;
    localparam logic [15:0] COEF_Y_G = 16'd129;
    localparam logic [15:0] COEF_Y_B = 16'd25;
    localparam logic [7:0]  LUMA_OFFSET = 8'd16;
    localparam logic [16:0] CHROMA_BIAS = 17'd32768;
    localparam logic [16:0] COEF_U_R = 17'd38;
    localparam logic [16:0] COEF_U_G = 17'd74;
    localparam logic [16:0] COEF_U_B = 17'd112;
    localparam logic [16:0] COEF_V_R = 17'd112;
    localparam logic [16:0] COEF_V_G = 17'd94;
    localparam logic [16:0] COEF_V_B = 17'd18;

    typedef enum logic [1:0] {
        PLANE_Y = 2'd0,
        PLANE_U = 2'd1,
        PLANE_V = 2'd2
    } plane_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [OFF_W-1:0] luma_off;
        logic [OFF_W-1:0] u_off;
        logic [OFF_W-1:0] v_off;
        logic             with_chroma;
        logic             frame_end;
    } ryuv_item_t;

endpackage

>>> sv/ryuv_front.sv
`timescale 1ns / 1ps

module ryuv_front
    import ryuv_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [0:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,
    input  logic             q_full,
    output logic             q_push,
    output ryuv_item_t       q_item
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int LW  = $clog2(MAX_HEIGHT);
    localparam int WDW = $clog2(MAX_WIDTH + 1);
    localparam int HDW = $clog2(MAX_HEIGHT + 1);
    localparam int PW  = WDW + HDW;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [WDW-1:0]   eff_w_reg;
    logic [WDW-1:0]   eff_w_next;
    logic [HDW-1:0]   eff_h_reg;
    logic [HDW-1:0]   eff_h_next;
    logic [PW-1:0]    size_reg;
    logic [OFF_W-1:0] u_base_reg;
    logic [OFF_W-1:0] v_base_reg;
    logic [1:0]       settle_reg;
    logic [1:0]       settle_next;

    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    col_next;
    logic [LW-1:0]    line_reg;
    logic [LW-1:0]    line_next;
    logic [OFF_W-1:0] luma_reg;
    logic [OFF_W-1:0] luma_next;
    logic [OFF_W-1:0] chroma_reg;
    logic [OFF_W-1:0] chroma_next;

    logic [WDW:0] col_inc;
    logic [HDW:0] line_inc;
    logic         line_end;
    logic         frame_last;
    logic         with_chroma;
    logic         accept;

    always_comb begin
        if (frame_width_reg < CFG_W'(2)) begin
            eff_w_next = WDW'(2);
        end else if (32'(frame_width_reg) > MAX_WIDTH) begin
            eff_w_next = WDW'(MAX_WIDTH);
        end else begin
            eff_w_next = WDW'(frame_width_reg);
        end
        eff_w_next = eff_w_next & ~WDW'(1);

        if (frame_height_reg < CFG_W'(2)) begin
            eff_h_next = HDW'(2);
        end else if (32'(frame_height_reg) > MAX_HEIGHT) begin
            eff_h_next = HDW'(MAX_HEIGHT);
        end else begin
            eff_h_next = HDW'(frame_height_reg);
        end
        eff_h_next = eff_h_next & ~HDW'(1);
    end

    // Plane bases follow the dimension registers through three register stages.
    always_ff @(posedge aclk) begin
        eff_w_reg  <= eff_w_next;
        eff_h_reg  <= eff_h_next;
        size_reg   <= PW'(eff_w_reg) * PW'(eff_h_reg);
        u_base_reg <= OFF_W'(size_reg);
        v_base_reg <= OFF_W'(size_reg + (size_reg >> 2));
    end

    always_comb begin
        settle_next = settle_reg;
        if (cfg_wr_en) begin
            settle_next = 2'd3;
        end else if (settle_reg != 2'd0) begin
            settle_next = settle_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            settle_reg       <= 2'd3;
        end else begin
            settle_reg <= settle_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_FRAME_WIDTH: begin
                        frame_width_reg <= cfg_wdata;
                    end
                    REG_FRAME_HEIGHT: begin
                        frame_height_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign s_tready = (settle_reg == 2'd0) && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    assign col_inc     = (WDW + 1)'(col_reg) + (WDW + 1)'(1);
    assign line_inc    = (HDW + 1)'(line_reg) + (HDW + 1)'(1);
    assign line_end    = col_inc >= (WDW + 1)'(eff_w_reg);
    assign frame_last  = line_end && (line_inc >= (HDW + 1)'(eff_h_reg));
    assign with_chroma = !col_reg[0] && !line_reg[0];

    always_comb begin
        col_next    = col_reg;
        line_next   = line_reg;
        luma_next   = luma_reg;
        chroma_next = chroma_reg;
        if (accept) begin
            if (with_chroma) begin
                chroma_next = chroma_reg + OFF_W'(1);
            end
            if (frame_last) begin
                col_next    = '0;
                line_next   = '0;
                luma_next   = '0;
                chroma_next = '0;
            end else if (line_end) begin
                col_next  = '0;
                line_next = line_reg + LW'(1);
                luma_next = luma_reg + OFF_W'(1);
            end else begin
                col_next  = col_reg + CW'(1);
                luma_next = luma_reg + OFF_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            line_reg   <= '0;
            luma_reg   <= '0;
            chroma_reg <= '0;
        end else begin
            col_reg    <= col_next;
            line_reg   <= line_next;
            luma_reg   <= luma_next;
            chroma_reg <= chroma_next;
        end
    end

    always_comb begin
        q_item.red         = s_tdata[7:0];
        q_item.green       = s_tdata[15:8];
        q_item.blue        = s_tdata[23:16];
        q_item.luma_off    = luma_reg;
        q_item.u_off       = u_base_reg + chroma_reg;
        q_item.v_off       = v_base_reg + chroma_reg;
        q_item.with_chroma = with_chroma;
        q_item.frame_end   = frame_last;
    end

endmodule

>>> sv/ryuv_queue.sv
`timescale 1ns / 1ps

module ryuv_queue
    import ryuv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  ryuv_item_t push_item,
    output logic       full,
    input  logic       pop,
    output ryuv_item_t pop_item,
    output logic       empty
);

    ryuv_item_t          entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign full     = count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QUEUE_AW + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QUEUE_AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
        end
    end

endmodule

>>> sv/ryuv_back.sv
`timescale 1ns / 1ps
`include "rgb_to_yuv420_planar_unit_assert.svh"

module ryuv_back
    import ryuv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  ryuv_item_t  q_item,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        PH_Y = 3'b001,
        PH_U = 3'b010,
        PH_V = 3'b100
    } phase_t;

    logic             work_valid_reg;
    logic             work_valid_next;
    phase_t           phase_reg;
    phase_t           phase_next;
    ryuv_item_t       work_reg;
    logic [PIX_W-1:0] y_reg;
    logic [PIX_W-1:0] u_reg;
    logic [PIX_W-1:0] v_reg;

    logic             m_tvalid_reg;
    plane_t           out_plane_reg;
    logic [OFF_W-1:0] out_off_reg;
    logic [PIX_W-1:0] out_val_reg;
    logic             m_tlast_reg;
    logic             out_fend_reg;

    plane_t           sel_plane;
    logic [OFF_W-1:0] sel_off;
    logic [PIX_W-1:0] sel_val;
    logic             last_phase;
    logic             out_load;
    logic             work_free;

    logic [15:0] y_sum;
    logic [16:0] u_sum;
    logic [16:0] v_sum;

    // Arithmetic shift is a plain shift here because the bias keeps the sums non-negative.
    assign y_sum = 16'(q_item.red) * COEF_Y_R + 16'(q_item.green) * COEF_Y_G
                 + 16'(q_item.blue) * COEF_Y_B;
    assign u_sum = CHROMA_BIAS + 17'(q_item.blue) * COEF_U_B
                 - 17'(q_item.red) * COEF_U_R - 17'(q_item.green) * COEF_U_G;
    assign v_sum = CHROMA_BIAS + 17'(q_item.red) * COEF_V_R
                 - 17'(q_item.green) * COEF_V_G - 17'(q_item.blue) * COEF_V_B;

    assign last_phase = (phase_reg == PH_V) || ((phase_reg == PH_Y) && !work_reg.with_chroma);
    assign out_load   = work_valid_reg && (!m_tvalid_reg || m_tready);
    assign work_free  = !work_valid_reg || (out_load && last_phase);
    assign q_pop      = !q_empty && work_free;

    always_comb begin
        case (phase_reg)
            PH_Y: begin
                sel_plane = PLANE_Y;
                sel_off   = work_reg.luma_off;
                sel_val   = y_reg;
            end
            PH_U: begin
                sel_plane = PLANE_U;
                sel_off   = work_reg.u_off;
                sel_val   = u_reg;
            end
            PH_V: begin
                sel_plane = PLANE_V;
                sel_off   = work_reg.v_off;
                sel_val   = v_reg;
            end
            default: begin
                sel_plane = PLANE_Y;
                sel_off   = work_reg.luma_off;
                sel_val   = y_reg;
            end
        endcase
    end

    always_comb begin
        work_valid_next = work_valid_reg;
        phase_next      = phase_reg;
        if (q_pop) begin
            work_valid_next = 1'b1;
            phase_next      = PH_Y;
        end else if (out_load) begin
            if (last_phase) begin
                work_valid_next = 1'b0;
            end else if (phase_reg == PH_Y) begin
                phase_next = PH_U;
            end else begin
                phase_next = PH_V;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
            phase_reg      <= PH_Y;
            m_tvalid_reg   <= 1'b0;
        end else begin
            work_valid_reg <= work_valid_next;
            phase_reg      <= phase_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            work_reg <= q_item;
            y_reg    <= y_sum[15:8] + LUMA_OFFSET;
            u_reg    <= u_sum[15:8];
            v_reg    <= v_sum[15:8];
        end
        if (out_load) begin
            out_plane_reg <= sel_plane;
            out_off_reg   <= sel_off;
            out_val_reg   <= sel_val;
            m_tlast_reg   <= last_phase;
            out_fend_reg  <= work_reg.frame_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_val_reg, out_off_reg};
    assign m_tuser  = {out_fend_reg, out_plane_reg};
    assign m_tlast  = m_tlast_reg;

    `RYUV_ASSERT_NOW(a_u_then_v, aclk, aresetn, m_tvalid_reg && out_plane_reg == PLANE_U, work_valid_reg && phase_reg == PH_V, "V sample not pending behind U")
    `RYUV_ASSERT_NOW(a_y_then_u, aclk, aresetn, m_tvalid_reg && out_plane_reg == PLANE_Y && !m_tlast_reg, work_valid_reg && phase_reg == PH_U, "U sample not pending behind Y")
    `RYUV_ASSERT_NOW(a_v_is_last, aclk, aresetn, m_tvalid_reg && out_plane_reg == PLANE_V, m_tlast_reg, "V sample without last flag")
    `RYUV_ASSERT_NEXT(a_pop_loads, aclk, aresetn, q_pop, work_valid_reg && phase_reg == PH_Y, "popped item not loaded at luma phase")

endmodule

>>> sv/rgb_to_yuv420_planar_unit.sv
`timescale 1ns / 1ps
// Order: the Y result passes from the queue through the work register to the output
// register; U and V follow behind it in turn when the output is not stalled.
// Throughput: one result per cycle from the output register while m_tready is high;
// a pixel yields one result, or three when it also carries U and V; a two-item queue
// decouples input from output. Reset: counters cleared, frame size 640 x 480; input is
// held off after reset and every configuration write while plane bases are recomputed.

module rgb_to_yuv420_planar_unit
    import ryuv_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [0:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [23:0]      s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // byte_offset [22:0], sample_value [30:23], zero fill [31]
    output logic [31:0]      m_tdata,
    // plane [1:0], frame_end [2]
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    ryuv_item_t push_item;
    ryuv_item_t pop_item;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;

    ryuv_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (push),
        .q_item    (push_item)
    );

    ryuv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    ryuv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_item   (pop_item),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> tb/sv/yuv420_sample_checker.sv
`timescale 1ns / 1ps

module yuv420_sample_checker
    import ryuv_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [0:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [23:0]      s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    // byte_offset [22:0], sample_value [30:23], zero fill [31]
    input  logic [31:0]      m_tdata,
    // plane [1:0], frame_end [2]
    input  logic [2:0]       m_tuser,
    input  logic             m_tlast,
    output int               mismatch_count,
    output int               pending_samples
);

    typedef struct packed {
        plane_t           plane;
        logic [OFF_W-1:0] offset;
        logic [7:0]       value;
        logic             last_of_pixel;
        logic             frame_end;
    } yuv_sample_t;

    yuv_sample_t      expected_samples[$];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      column_pos;
    int unsigned      line_pos;
    int unsigned      luma_pos;
    int unsigned      chroma_pos;

    function automatic int unsigned usable_dim(logic [CFG_W-1:0] reg_value, int unsigned limit);
        int unsigned dim;
        dim = reg_value;
        if (dim < 2) begin
            dim = 2;
        end
        if (dim > limit) begin
            dim = limit;
        end
        return dim & ~32'd1;
    endfunction

    function automatic yuv_sample_t make_sample(plane_t plane, int unsigned offset, int value,
                                                logic last_of_pixel, logic frame_end);
        yuv_sample_t sample;
        sample.plane = plane;
        sample.offset = offset[OFF_W-1:0];
        sample.value = value[7:0];
        sample.last_of_pixel = last_of_pixel;
        sample.frame_end = frame_end;
        return sample;
    endfunction

    task automatic convert_pixel(input logic [23:0] pixel);
        int          red;
        int          green;
        int          blue;
        int unsigned w;
        int unsigned h;
        int unsigned luma_size;
        logic        line_end;
        logic        frame_last;
        logic        with_chroma;
        int          luma;
        int          chroma_u;
        int          chroma_v;
        red = pixel[7:0];
        green = pixel[15:8];
        blue = pixel[23:16];
        w = usable_dim(width_reg, MAX_WIDTH);
        h = usable_dim(height_reg, MAX_HEIGHT);
        luma_size = w * h;
        line_end = (column_pos + 1 >= w);
        frame_last = line_end && (line_pos + 1 >= h);
        with_chroma = !line_pos[0] && !column_pos[0];
        luma = ((66 * red + 129 * green + 25 * blue) >>> 8) + 16;
        expected_samples.push_back(make_sample(PLANE_Y, luma_pos, luma, !with_chroma,
                                               frame_last));
        if (with_chroma) begin
            chroma_u = (32768 + 112 * blue - 38 * red - 74 * green) >>> 8;
            chroma_v = (32768 + 112 * red - 94 * green - 18 * blue) >>> 8;
            expected_samples.push_back(make_sample(PLANE_U, luma_size + chroma_pos, chroma_u,
                                                   1'b0, frame_last));
            expected_samples.push_back(make_sample(PLANE_V,
                                                   luma_size + luma_size / 4 + chroma_pos,
                                                   chroma_v, 1'b1, frame_last));
            chroma_pos++;
        end
        if (frame_last) begin
            column_pos = 0;
            line_pos = 0;
            luma_pos = 0;
            chroma_pos = 0;
        end else if (line_end) begin
            column_pos = 0;
            line_pos++;
            luma_pos++;
        end else begin
            column_pos++;
            luma_pos++;
        end
    endtask

    always @(posedge aclk) begin
        yuv_sample_t got;
        yuv_sample_t want;
        if (!aresetn) begin
            width_reg = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            column_pos = 0;
            line_pos = 0;
            luma_pos = 0;
            chroma_pos = 0;
            mismatch_count = 0;
            expected_samples.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.plane = plane_t'(m_tuser[1:0]);
                got.offset = m_tdata[22:0];
                got.value = m_tdata[30:23];
                got.last_of_pixel = m_tlast;
                got.frame_end = m_tuser[2];
                if (expected_samples.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Unexpected item: plane %0d offset %0d value %0d last %0b end %0b",
                                 got.plane, got.offset, got.value, got.last_of_pixel,
                                 got.frame_end);
                    end
                end else begin
                    want = expected_samples.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("Mismatch: expected plane %0d offset %0d value %0d last %0b end %0b",
                                     want.plane, want.offset, want.value, want.last_of_pixel,
                                     want.frame_end);
                            $display("          got      plane %0d offset %0d value %0d last %0b end %0b",
                                     got.plane, got.offset, got.value, got.last_of_pixel,
                                     got.frame_end);
                        end
                    end
                end
            end
            if (cfg_wr_en) begin
                if (cfg_addr == REG_FRAME_WIDTH) begin
                    width_reg = cfg_wdata;
                end else begin
                    height_reg = cfg_wdata;
                end
            end
            if (s_tvalid && s_tready) begin
                convert_pixel(s_tdata);
            end
        end
        pending_samples = expected_samples.size();
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ryuv_pkg::*;

    localparam int RUN_LIMIT = 400000;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [0:0]       cfg_addr = REG_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [23:0]      s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [31:0]      m_tdata;
    logic [2:0]       m_tuser;
    logic             m_tlast;
    int               mismatch_count;
    int               pending_samples;
    int               idle_pct = 0;
    int               stall_pct = 0;
    int unsigned      cycle_count = 0;

    rgb_to_yuv420_planar_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    yuv420_sample_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_samples(pending_samples)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [23:0] corner_pixel(int k);
        logic [23:0] corners [8];
        corners = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
                    24'hFF0000, 24'h00FFFF, 24'hFFFF00, 24'hFF00FF};
        return corners[k % 8];
    endfunction

    function automatic logic [7:0] random_component();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pixel(input logic [23:0] pixel);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pixel;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_samples != 0) begin
            @(posedge aclk);
        end
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height);
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_FRAME_WIDTH;
        cfg_wdata <= width;
        @(posedge aclk);
        cfg_addr <= REG_FRAME_HEIGHT;
        cfg_wdata <= height;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int          phase_idle [4];
        int          phase_stall [4];
        logic [11:0] width;
        logic [11:0] height;
        phase_idle = '{0, 73, 0, 31};
        phase_stall = '{0, 0, 73, 31};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < 3; k++) begin
            send_pixel(corner_pixel(k));
        end
        drain_results();
        set_frame(12'd4, 12'd2);
        for (int k = 0; k < 8; k++) begin
            send_pixel(corner_pixel(k + 3));
        end
        drain_results();
        set_frame(12'd0, 12'd1);
        for (int k = 0; k < 4; k++) begin
            send_pixel(corner_pixel(k + 1));
        end
        drain_results();
        set_frame(12'd4095, 12'd4095);
        for (int k = 0; k < 4; k++) begin
            send_pixel(corner_pixel(k + 5));
        end
        // Shrinking the frame while the column is past the new width ends the line.
        drain_results();
        set_frame(12'd3, 12'd3);
        for (int k = 0; k < 4; k++) begin
            send_pixel(corner_pixel(k + 2));
        end
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = phase_idle[phase];
            stall_pct = phase_stall[phase];
            for (int run = 0; run < 4; run++) begin
                case ($urandom_range(7))
                    0: begin
                        width = 12'($urandom_range(4095));
                        height = 12'($urandom_range(4095));
                    end
                    1: begin
                        width = 12'(2 * $urandom_range(4) + 1);
                        height = 12'(2 * $urandom_range(3) + 1);
                    end
                    default: begin
                        width = 12'(2 * $urandom_range(1, 4));
                        height = 12'(2 * $urandom_range(1, 3));
                    end
                endcase
                set_frame(width, height);
                for (int k = 0; k < 20; k++) begin
                    send_pixel({random_component(), random_component(), random_component()});
                end
                drain_results();
            end
        end

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
